@@ rtl/core/cud_pkg.sv @@
// Shared types and constants for the chunked upload deframer.
`timescale 1ns / 1ps

package cud_pkg;

  localparam int unsigned WORD_BYTES = 16;

  typedef enum logic [1:0] {
    KIND_WORD     = 2'd0,
    KIND_NAME     = 2'd1,
    KIND_PAYLOAD  = 2'd2,
    KIND_REJECTED = 2'd3
  } cud_kind_t;

  localparam logic [7:0] CFG_MAX_CHUNK_SIZE   = 8'd0;
  localparam logic [7:0] CFG_MAX_TOTAL_CHUNKS = 8'd1;

  localparam logic [15:0] MAX_CHUNK_SIZE_RST   = 16'd8192;
  localparam logic [31:0] MAX_TOTAL_CHUNKS_RST = 32'd2000000;

  typedef struct packed {
    cud_kind_t   byte_kind;
    logic [7:0]  byte_out;
    logic        first_chunk_start;
    logic        chunk_end;
    logic        transfer_done;
    logic [31:0] chunk_index;
    logic [31:0] chunks_done;
  } cud_result_t;

endpackage

@@ rtl/core/cud_obuf.sv @@
// Two-entry output buffer that decouples the result channel from the input side.
`timescale 1ns / 1ps

module cud_obuf
  import cud_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cud_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output cud_result_t out_data
);

  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  cud_result_t slot0_r;
  cud_result_t slot1_r;
  logic        pop;

  assign pop       = (count_r != 2'd0) && !out_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot0_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk) begin
    if (count_r == 2'd2) begin
      if (pop) begin
        slot0_r <= slot1_r;
      end
    end else if (count_r == 2'd1) begin
      if (push && pop) begin
        slot0_r <= push_data;
      end else if (push) begin
        slot1_r <= push_data;
      end
    end else begin
      if (push) begin
        slot0_r <= push_data;
      end
    end
  end

endmodule

@@ rtl/core/chunked_upload_deframer_core.sv @@
// Top level of the chunked upload deframer: header parse, payload count, result buffer.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) carries one stream byte
//   per item. Every accepted byte yields exactly one result item on the
//   output channel (out_valid / out_stall / out_* fields).
//   A chunk is a 16-byte header of four big-endian words (id, size, total,
//   type) plus NAME_BYTES name bytes, then size payload bytes. A bad header
//   is flagged with byte kind "rejected" on its last byte.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the
//   chunk size and total chunk limits; write it only while the block is idle.
// Results are registered in the result buffer before they reach the output channel.
// Throughput: one byte per cycle while the result buffer is not full; the per-byte
//   work is one counter step and the limit compares, done between the input
//   handshake and the result buffer.
// Reset (rst_n low, synchronous): counters and header words clear, limits
//   return to 8192 and 2000000, the result buffer empties.
// Receiver stall: a two-entry result buffer keeps taking bytes while one
//   result waits; in_stall rises only when both entries are occupied.
module chunked_upload_deframer_core
  import cud_pkg::*;
#(
  parameter int unsigned NAME_BYTES = 64
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_byte_kind,
  output logic [7:0]  out_byte_out,
  output logic        out_first_chunk_start,
  output logic        out_chunk_end,
  output logic        out_transfer_done,
  output logic [31:0] out_chunk_index,
  output logic [31:0] out_chunks_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned HEADER_BYTES = WORD_BYTES + NAME_BYTES;
  localparam int unsigned CNT_W        = $clog2(HEADER_BYTES);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(HEADER_BYTES - 1);

  // Limits
  logic [15:0] max_chunk_size_r;
  logic [31:0] max_total_chunks_r;

  // Deframer state
  logic [CNT_W-1:0] hdr_cnt_r,    hdr_cnt_nxt;
  logic             in_payload_r, in_payload_nxt;
  logic [31:0]      id_word_r,    id_word_nxt;
  logic [31:0]      size_word_r,  size_word_nxt;
  logic [31:0]      total_word_r, total_word_nxt;
  logic [15:0]      pay_left_r,   pay_left_nxt;
  logic [31:0]      expected_r,   expected_nxt;
  logic [31:0]      received_r,   received_nxt;

  logic        accept;
  logic        buf_full;
  logic        hdr_bad;
  logic [15:0] pay_dec;
  logic [31:0] recv_inc;
  cud_result_t res;
  cud_result_t out_res;

  assign in_stall  = buf_full;
  assign accept    = in_valid && !buf_full;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunk_size_r   <= MAX_CHUNK_SIZE_RST;
      max_total_chunks_r <= MAX_TOTAL_CHUNKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_CHUNK_SIZE:   max_chunk_size_r   <= cfg_data[15:0];
        CFG_MAX_TOTAL_CHUNKS: max_total_chunks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Header check uses the words as they stand once the last word byte is in;
  // name bytes never touch them.
  assign hdr_bad = (size_word_r == 32'd0) || (total_word_r == 32'd0) ||
                   (size_word_r > {16'd0, max_chunk_size_r}) ||
                   (total_word_r > max_total_chunks_r);

  assign pay_dec  = (pay_left_r != 16'd0) ? (pay_left_r - 16'd1) : 16'd0;
  assign recv_inc = received_r + 32'd1;

  always_comb begin
    hdr_cnt_nxt    = hdr_cnt_r;
    in_payload_nxt = in_payload_r;
    id_word_nxt    = id_word_r;
    size_word_nxt  = size_word_r;
    total_word_nxt = total_word_r;
    pay_left_nxt   = pay_left_r;
    expected_nxt   = expected_r;
    received_nxt   = received_r;

    res                   = '0;
    res.byte_out          = in_data_byte;
    res.byte_kind         = KIND_WORD;

    if (!in_payload_r) begin
      // Shift the byte into its header word; type word bytes are dropped.
      if (hdr_cnt_r < CNT_W'(WORD_BYTES)) begin
        res.byte_kind = KIND_WORD;
        if (hdr_cnt_r < CNT_W'(4)) begin
          id_word_nxt = {id_word_r[23:0], in_data_byte};
        end else if (hdr_cnt_r < CNT_W'(8)) begin
          size_word_nxt = {size_word_r[23:0], in_data_byte};
        end else if (hdr_cnt_r < CNT_W'(12)) begin
          total_word_nxt = {total_word_r[23:0], in_data_byte};
        end
      end else begin
        res.byte_kind = KIND_NAME;
      end

      if (hdr_cnt_r == LAST_POS) begin
        hdr_cnt_nxt = '0;
        if (hdr_bad) begin
          res.byte_kind = KIND_REJECTED;
        end else begin
          in_payload_nxt = 1'b1;
          pay_left_nxt   = size_word_r[15:0];
          if (id_word_r == 32'd0) begin
            expected_nxt          = total_word_r;
            received_nxt          = 32'd0;
            res.first_chunk_start = 1'b1;
          end
        end
      end else begin
        hdr_cnt_nxt = hdr_cnt_r + CNT_W'(1);
      end
      res.chunks_done = received_nxt;
    end else begin
      res.byte_kind = KIND_PAYLOAD;
      pay_left_nxt  = pay_dec;
      res.chunks_done = received_r;
      if (pay_dec == 16'd0) begin
        // Last payload byte: close the chunk, count it, test for completion.
        res.chunk_end   = 1'b1;
        in_payload_nxt  = 1'b0;
        hdr_cnt_nxt     = '0;
        received_nxt    = recv_inc;
        res.chunks_done = recv_inc;
        if (recv_inc >= expected_r) begin
          res.transfer_done = 1'b1;
          received_nxt      = 32'd0;
          expected_nxt      = 32'd0;
          pay_left_nxt      = 16'd0;
        end
      end
    end

    res.chunk_index = id_word_nxt;
  end

  // Advance state only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r    <= '0;
      in_payload_r <= 1'b0;
      id_word_r    <= 32'd0;
      size_word_r  <= 32'd0;
      total_word_r <= 32'd0;
      pay_left_r   <= 16'd0;
      expected_r   <= 32'd0;
      received_r   <= 32'd0;
    end else if (accept) begin
      hdr_cnt_r    <= hdr_cnt_nxt;
      in_payload_r <= in_payload_nxt;
      id_word_r    <= id_word_nxt;
      size_word_r  <= size_word_nxt;
      total_word_r <= total_word_nxt;
      pay_left_r   <= pay_left_nxt;
      expected_r   <= expected_nxt;
      received_r   <= received_nxt;
    end
  end

  cud_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_byte_kind         = out_res.byte_kind;
  assign out_byte_out          = out_res.byte_out;
  assign out_first_chunk_start = out_res.first_chunk_start;
  assign out_chunk_end         = out_res.chunk_end;
  assign out_transfer_done     = out_res.transfer_done;
  assign out_chunk_index       = out_res.chunk_index;
  assign out_chunks_done       = out_res.chunks_done;

endmodule
